@@ sv/dshe_pkg.sv @@
package dshe_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned AddrW = 5;

  localparam logic [31:0] FnvPrime  = 32'd16777619;
  localparam logic [31:0] FnvSeed   = 32'd2166136261;
  localparam logic [31:0] OaatSeed  = 32'h6a09e667;
  localparam logic [31:0] OaatAdd   = 32'h9e3779b9;
  localparam logic [31:0] HeaderTag = 32'h53544154;
  localparam logic [31:0] KindMaskRst = 32'hffffffff;

  localparam logic [31:0] TagGenHeap = 32'h10000000;
  localparam logic [31:0] TagGfxHeap = 32'h18000000;
  localparam logic [31:0] TagMainRam = 32'h20000000;
  localparam logic [31:0] TagFastRam = 32'h30000000;
  localparam logic [31:0] TagSharedRam = 32'h40000000;
  localparam logic [31:0] TagVideoRam = 32'h50000000;

  localparam logic [31:0] MainRamLo   = 32'h02000000;
  localparam logic [31:0] MainRamHi   = 32'h02400000;
  localparam logic [31:0] FastRamLo   = 32'h01ff8000;
  localparam logic [31:0] SharedRamLo = 32'h02ff0000;
  localparam logic [31:0] SharedRamHi = 32'h03000000;
  localparam logic [31:0] VideoRamLo  = 32'h06000000;
  localparam logic [31:0] VideoRamHi  = 32'h07000000;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_FINISH = 2'd3
  } dshe_cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_MIX,
    OP_HEADER,
    OP_REPORT
  } dshe_op_e;

  typedef enum logic [2:0] {
    REG_GEN_BASE  = 3'd0,
    REG_GEN_TOP   = 3'd1,
    REG_GFX_BASE  = 3'd2,
    REG_GFX_END   = 3'd3,
    REG_KIND_MASK = 3'd4
  } dshe_reg_e;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } dshe_bk_state_e;

  typedef struct packed {
    logic [31:0] gen_base;
    logic [31:0] gen_top;
    logic [31:0] gfx_base;
    logic [31:0] gfx_end;
    logic [31:0] kind_mask;
  } dshe_cfg_t;

  typedef struct packed {
    dshe_op_e    op;
    logic [31:0] arg_a;
    logic [23:0] arg_b;
  } dshe_entry_t;

  function automatic logic [31:0] fnv_mix(input logic [31:0] acc, input logic [31:0] v);
    return (acc ^ v) * FnvPrime;
  endfunction

  function automatic logic [31:0] oaat_mix(input logic [31:0] acc, input logic [31:0] v);
    logic [31:0] t;
    t = acc + v + OaatAdd;
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] oaat_final(input logic [31:0] acc);
    logic [31:0] t;
    t = acc + (acc << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

@@ sv/dshe_if.sv @@
interface dshe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  record_kind;
  logic [23:0] record_length;
  logic [31:0] data_word;

  modport source (output valid, command, record_kind, record_length, data_word,
                  input ready);
  modport sink (input valid, command, record_kind, record_length, data_word,
                output ready);
endinterface

interface dshe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_hash;
  logic [31:0] second_hash;
  logic [31:0] byte_total;
  logic [31:0] record_total;

  modport source (output valid, first_hash, second_hash, byte_total, record_total,
                  input ready);
  modport sink (input valid, first_hash, second_hash, byte_total, record_total,
                output ready);
endinterface

@@ sv/dshe_front.sv @@
module dshe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dshe_pkg::dshe_cfg_t   cfg_i,
  dshe_in_if.sink               in_if,
  input  logic                  full_i,
  output logic                  push_o,
  output dshe_pkg::dshe_entry_t push_entry_o
);

  logic            enabled_q, enabled_d;
  logic            accept;
  logic            kind_hit;
  logic [31:0]     canon;
  dshe_pkg::dshe_cmd_e cmd;

  function automatic logic in_window(input logic [31:0] lo, input logic [31:0] hi,
                                     input logic [31:0] v);
    return (lo != '0) && (hi >= lo) && (v >= lo) && (v < hi);
  endfunction

  // word canonicalization, priority order
  always_comb begin
    logic [31:0] v;
    logic [31:0] b;
    v = {in_if.data_word[31:1], 1'b0};
    b = {31'd0, in_if.data_word[0]};
    if (in_if.data_word == '0) begin
      canon = '0;
    end else if (in_window(cfg_i.gen_base, cfg_i.gen_top, v)) begin
      canon = dshe_pkg::TagGenHeap | (v - cfg_i.gen_base) | b;
    end else if (in_window(cfg_i.gfx_base, cfg_i.gfx_end, v)) begin
      canon = dshe_pkg::TagGfxHeap | (v - cfg_i.gfx_base) | b;
    end else if (v >= dshe_pkg::MainRamLo && v < dshe_pkg::MainRamHi) begin
      canon = dshe_pkg::TagMainRam | b;
    end else if (v >= dshe_pkg::FastRamLo && v < dshe_pkg::MainRamLo) begin
      canon = dshe_pkg::TagFastRam | b;
    end else if (v >= dshe_pkg::SharedRamLo && v < dshe_pkg::SharedRamHi) begin
      canon = dshe_pkg::TagSharedRam | b;
    end else if (v >= dshe_pkg::VideoRamLo && v < dshe_pkg::VideoRamHi) begin
      canon = dshe_pkg::TagVideoRam | (v - dshe_pkg::VideoRamLo) | b;
    end else begin
      canon = in_if.data_word;
    end
  end

  assign cmd      = dshe_pkg::dshe_cmd_e'(in_if.command);
  assign kind_hit = cfg_i.kind_mask[in_if.record_kind];

  always_comb begin
    in_if.ready        = !full_i;
    accept             = in_if.valid && !full_i;
    enabled_d          = enabled_q;
    push_o             = 1'b0;
    push_entry_o.op    = dshe_pkg::OP_CLEAR;
    push_entry_o.arg_a = canon;
    push_entry_o.arg_b = in_if.record_length;
    unique case (cmd)
      dshe_pkg::CMD_START: begin
        push_o = accept;
        if (accept) begin
          enabled_d = 1'b0;
        end
      end
      dshe_pkg::CMD_HEADER: begin
        push_entry_o.op    = dshe_pkg::OP_HEADER;
        push_entry_o.arg_a = dshe_pkg::HeaderTag ^ {27'd0, in_if.record_kind};
        push_o             = accept && kind_hit;
        if (accept) begin
          enabled_d = kind_hit;
        end
      end
      dshe_pkg::CMD_DATA: begin
        push_entry_o.op = dshe_pkg::OP_MIX;
        push_o          = accept && enabled_q;
      end
      dshe_pkg::CMD_FINISH: begin
        push_entry_o.op = dshe_pkg::OP_REPORT;
        push_o          = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
    end
  end

endmodule

@@ sv/dshe_queue.sv @@
module dshe_queue #(
  parameter int unsigned Depth = dshe_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dshe_pkg::dshe_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output dshe_pkg::dshe_entry_t head_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dshe_pkg::dshe_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/dshe_back.sv @@
module dshe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  dshe_pkg::dshe_entry_t head_entry_i,
  output logic                  pop_o,
  dshe_out_if.source            out_if
);

  dshe_pkg::dshe_bk_state_e state_q, state_d;
  logic [31:0] fnv_q, fnv_d;
  logic [31:0] oaat_q, oaat_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] records_q, records_d;
  logic        out_valid_q, out_valid_d;
  logic        load_out;
  logic [31:0] mix_val;
  logic [31:0] len_ext;

  logic [31:0] h1_q, h2_q, bt_q, rt_q;

  assign len_ext = {8'd0, head_entry_i.arg_b};
  assign mix_val = (head_entry_i.op == dshe_pkg::OP_HEADER && state_q == dshe_pkg::BK_SECOND)
                   ? len_ext : head_entry_i.arg_a;

  always_comb begin
    state_d   = state_q;
    fnv_d     = fnv_q;
    oaat_d    = oaat_q;
    bytes_d   = bytes_q;
    records_d = records_q;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    if (head_valid_i) begin
      unique case (head_entry_i.op)
        dshe_pkg::OP_CLEAR: begin
          fnv_d     = dshe_pkg::FnvSeed;
          oaat_d    = dshe_pkg::OaatSeed;
          bytes_d   = '0;
          records_d = '0;
          pop_o     = 1'b1;
        end
        dshe_pkg::OP_MIX: begin
          fnv_d  = dshe_pkg::fnv_mix(fnv_q, mix_val);
          oaat_d = dshe_pkg::oaat_mix(oaat_q, mix_val);
          pop_o  = 1'b1;
        end
        dshe_pkg::OP_HEADER: begin
          fnv_d  = dshe_pkg::fnv_mix(fnv_q, mix_val);
          oaat_d = dshe_pkg::oaat_mix(oaat_q, mix_val);
          unique case (state_q)
            dshe_pkg::BK_FIRST: begin
              state_d = dshe_pkg::BK_SECOND;
            end
            dshe_pkg::BK_SECOND: begin
              state_d   = dshe_pkg::BK_FIRST;
              bytes_d   = bytes_q + len_ext;
              records_d = records_q + 32'd1;
              pop_o     = 1'b1;
            end
            default: begin
              state_d = dshe_pkg::BK_FIRST;
            end
          endcase
        end
        dshe_pkg::OP_REPORT: begin
          load_out = !out_valid_q || out_if.ready;
          pop_o    = load_out;
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dshe_pkg::BK_FIRST;
      fnv_q       <= dshe_pkg::FnvSeed;
      oaat_q      <= dshe_pkg::OaatSeed;
      bytes_q     <= '0;
      records_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fnv_q       <= fnv_d;
      oaat_q      <= oaat_d;
      bytes_q     <= bytes_d;
      records_q   <= records_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      h1_q <= fnv_q;
      h2_q <= dshe_pkg::oaat_final(oaat_q);
      bt_q <= bytes_q;
      rt_q <= records_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.first_hash   = h1_q;
  assign out_if.second_hash  = h2_q;
  assign out_if.byte_total   = bt_q;
  assign out_if.record_total = rt_q;

endmodule

@@ sv/dual_state_hash_engine_top.sv @@
// Dual hash engine over framed records: FNV-1a style and one-at-a-time style
// hashes run side by side over canonicalized 32-bit words. The front accepts
// one beat per cycle while its queue (QueueDepth entries) has room; skipped
// headers and data outside an enabled record end there. The back retires one
// queued start or data word per cycle, and a finish likewise while the output
// register is free or being taken; an enabled header takes a tag mix, then a
// length mix, bounded by the single 32x32 FNV multiply per cycle. A finish
// passes via the queue to the output register and waits until taken. The
// user must write configuration over APB only while idle; not enforced.
module dual_state_hash_engine_top #(
  parameter int unsigned QueueDepth = dshe_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dshe_in_if.sink                    in_if,
  dshe_out_if.source                 out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dshe_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  dshe_pkg::dshe_cfg_t   cfg_q;
  dshe_pkg::dshe_reg_e   reg_idx;
  dshe_pkg::dshe_entry_t push_entry, head_entry;
  logic                  push, pop, full, head_valid;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = dshe_pkg::dshe_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gen_base  <= '0;
      cfg_q.gen_top   <= '0;
      cfg_q.gfx_base  <= '0;
      cfg_q.gfx_end   <= '0;
      cfg_q.kind_mask <= dshe_pkg::KindMaskRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        dshe_pkg::REG_GEN_BASE:  cfg_q.gen_base  <= pwdata;
        dshe_pkg::REG_GEN_TOP:   cfg_q.gen_top   <= pwdata;
        dshe_pkg::REG_GFX_BASE:  cfg_q.gfx_base  <= pwdata;
        dshe_pkg::REG_GFX_END:   cfg_q.gfx_end   <= pwdata;
        dshe_pkg::REG_KIND_MASK: cfg_q.kind_mask <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dshe_pkg::REG_GEN_BASE:  prdata = cfg_q.gen_base;
      dshe_pkg::REG_GEN_TOP:   prdata = cfg_q.gen_top;
      dshe_pkg::REG_GFX_BASE:  prdata = cfg_q.gfx_base;
      dshe_pkg::REG_GFX_END:   prdata = cfg_q.gfx_end;
      dshe_pkg::REG_KIND_MASK: prdata = cfg_q.kind_mask;
      default:                 prdata = '0;
    endcase
  end

  dshe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_if        (in_if),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  dshe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  dshe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_if       (out_if)
  );

endmodule

@@ sv/dshe_checker.sv @@
module dshe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] first_hash_i,
  input logic [31:0] second_hash_i,
  input logic [31:0] byte_total_i,
  input logic [31:0] record_total_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(first_hash_i) && $stable(second_hash_i)
      && $stable(byte_total_i) && $stable(record_total_i))
    else $error("result payload changed while stalled");

  a_no_early_result: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result beat right after reset");

endmodule

bind dual_state_hash_engine_top dshe_checker u_dshe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .first_hash_i   (out_if.first_hash),
  .second_hash_i  (out_if.second_hash),
  .byte_total_i   (out_if.byte_total),
  .record_total_i (out_if.record_total)
);
